>>> rtl/wlsp_pkg.sv
// Shared types and constants for the leapfrog wave stencil.
// No dependencies; imported by the cfg and result interfaces and all modules.
package wlsp_pkg;

  localparam int DEF_MAX_POINTS   = 1024;
  localparam int DEF_SAMPLE_WIDTH = 24;
  localparam int INDEX_WIDTH      = 10;
  localparam int C2_WIDTH         = 17;
  localparam int FRAC_BITS        = 16;

  localparam logic [C2_WIDTH-1:0] C2_RESET = 17'd16384;
  localparam logic [C2_WIDTH-1:0] C2_ONE   = 17'd65536;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_SAT   = 2'd1,
    STATUS_SHORT = 2'd2
  } status_t;

  typedef struct packed {
    logic                   short_sweep;
    logic                   end_of_run;
    logic [INDEX_WIDTH-1:0] point_index;
  } job_ctl_t;

endpackage

>>> rtl/wlsp_cfg_if.sv
// Configuration write channel: courant_squared register.
// Depends on wlsp_pkg.
interface wlsp_cfg_if import wlsp_pkg::*;;
  logic                valid;
  logic                ready;
  logic [C2_WIDTH-1:0] courant_squared;

  modport source (output valid, courant_squared, input ready);
  modport sink   (input valid, courant_squared, output ready);
endinterface

>>> rtl/wlsp_point_if.sv
// Input channel: one grid point item (present and previous sample).
// Does not import wlsp_pkg; the sample width is its own parameter.
interface wlsp_point_if #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] current_sample;
  logic signed [SAMPLE_WIDTH-1:0] previous_sample;
  logic                           last_point;

  modport source (output valid, current_sample, previous_sample, last_point, input ready);
  modport sink   (input valid, current_sample, previous_sample, last_point, output ready);
endinterface

>>> rtl/wlsp_result_if.sv
// Output channel: one updated grid point item with index and status.
// Depends on wlsp_pkg.
interface wlsp_result_if import wlsp_pkg::*; #(
  parameter int SAMPLE_WIDTH = 24
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] next_sample;
  logic [INDEX_WIDTH-1:0]         point_index;
  logic [1:0]                     status;
  logic                           end_of_run;

  modport source (output valid, next_sample, point_index, status, end_of_run, input ready);
  modport sink   (input valid, next_sample, point_index, status, end_of_run, output ready);
endinterface

>>> rtl/wlsp_front.sv
// Sweep tracking: sample window, head of sweep, point counter and a
// three-slot job register that feeds one stencil job per cycle while job_ready is high.
// Depends on wlsp_pkg and wlsp_point_if.
module wlsp_front import wlsp_pkg::*; #(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                           clk,
  input  logic                           rst,
  wlsp_point_if.sink                     points,
  output logic                           job_valid,
  input  logic                           job_ready,
  output job_ctl_t                       job_ctl,
  output logic signed [SAMPLE_WIDTH-1:0] job_left,
  output logic signed [SAMPLE_WIDTH-1:0] job_mid,
  output logic signed [SAMPLE_WIDTH-1:0] job_right,
  output logic signed [SAMPLE_WIDTH-1:0] job_old
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int CW = $clog2(MAX_POINTS);
  localparam int IW = (CW > INDEX_WIDTH) ? CW : INDEX_WIDTH;

  logic signed [W-1:0] win0, win1, dold, head0, head1, hold;
  logic [CW-1:0]       count;

  logic signed [W-1:0] s_left [3];
  logic signed [W-1:0] s_mid  [3];
  logic signed [W-1:0] s_right[3];
  logic signed [W-1:0] s_old  [3];
  job_ctl_t            s_ctl  [3];
  logic [1:0]          s_cnt;

  logic signed [W-1:0] n_left [3];
  logic signed [W-1:0] n_mid  [3];
  logic signed [W-1:0] n_right[3];
  logic signed [W-1:0] n_old  [3];
  job_ctl_t            n_ctl  [3];
  logic [1:0]          n_cnt;

  logic          accept, last, inner;
  logic [IW-1:0] idx_w, idx_m1_w;
  logic signed [W-1:0] cur, old;

  assign cur           = points.current_sample;
  assign old           = points.previous_sample;
  assign points.ready  = (s_cnt == 2'd0) || ((s_cnt == 2'd1) && job_ready);
  assign accept        = points.valid && points.ready;
  assign last          = points.last_point || (count == CW'(MAX_POINTS - 1));
  assign inner         = (count > CW'(1));
  assign idx_w         = IW'(count);
  assign idx_m1_w      = IW'(count - CW'(1));

  assign job_valid = (s_cnt != 2'd0);
  assign job_ctl   = s_ctl[0];
  assign job_left  = s_left[0];
  assign job_mid   = s_mid[0];
  assign job_right = s_right[0];
  assign job_old   = s_old[0];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      n_left[k]  = '0;
      n_mid[k]   = '0;
      n_right[k] = '0;
      n_old[k]   = '0;
      n_ctl[k]   = '0;
    end
    n_cnt = 2'd0;
    if (inner) begin
      n_left[0]              = win0;
      n_mid[0]               = win1;
      n_right[0]             = cur;
      n_old[0]               = dold;
      n_ctl[0].point_index   = idx_m1_w[INDEX_WIDTH-1:0];
      n_cnt                  = 2'd1;
      if (last) begin
        n_left[1]            = win1;
        n_mid[1]             = cur;
        n_right[1]           = head0;
        n_old[1]             = old;
        n_ctl[1].point_index = idx_w[INDEX_WIDTH-1:0];
        n_left[2]            = cur;
        n_mid[2]             = head0;
        n_right[2]           = head1;
        n_old[2]             = hold;
        n_ctl[2].end_of_run  = 1'b1;
        n_cnt                = 2'd3;
      end
    end else if (last) begin
      n_ctl[0].short_sweep = 1'b1;
      n_ctl[0].end_of_run  = 1'b1;
      n_cnt                = 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_cnt <= 2'd0;
      count <= '0;
      win0  <= '0;
      win1  <= '0;
      dold  <= '0;
      head0 <= '0;
      head1 <= '0;
      hold  <= '0;
    end else if (accept) begin
      s_cnt <= n_cnt;
      count <= last ? '0 : count + CW'(1);
      win0  <= win1;
      win1  <= cur;
      dold  <= old;
      if (count == '0) begin
        head0 <= cur;
        hold  <= old;
      end
      if (count == CW'(1)) begin
        head1 <= cur;
      end
    end else if (job_valid && job_ready) begin
      s_cnt <= s_cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        s_left[k]  <= n_left[k];
        s_mid[k]   <= n_mid[k];
        s_right[k] <= n_right[k];
        s_old[k]   <= n_old[k];
        s_ctl[k]   <= n_ctl[k];
      end
    end else if (job_valid && job_ready) begin
      for (int k = 0; k < 2; k++) begin
        s_left[k]  <= s_left[k+1];
        s_mid[k]   <= s_mid[k+1];
        s_right[k] <= s_right[k+1];
        s_old[k]   <= s_old[k+1];
        s_ctl[k]   <= s_ctl[k+1];
      end
    end
  end

endmodule

>>> rtl/wlsp_stencil.sv
// Two-stage stencil datapath: Laplacian and 2*mid-old, then the c2
// multiply, round, add and saturate into the result register.
// Depends on wlsp_pkg and wlsp_result_if.
module wlsp_stencil import wlsp_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [C2_WIDTH-1:0]           c2,
  input  logic                          job_valid,
  output logic                          job_ready,
  input  job_ctl_t                      job_ctl,
  input  logic signed [SAMPLE_WIDTH-1:0] job_left,
  input  logic signed [SAMPLE_WIDTH-1:0] job_mid,
  input  logic signed [SAMPLE_WIDTH-1:0] job_right,
  input  logic signed [SAMPLE_WIDTH-1:0] job_old,
  wlsp_result_if.source                 results
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int PW = W + 2 + C2_WIDTH + 1;
  localparam int TW = PW - FRAC_BITS;
  localparam int SW = W + 5;

  logic                  a_valid;
  job_ctl_t              a_ctl;
  logic signed [W+1:0]   a_lap, a_base;
  logic signed [W+1:0]   lap_next, base_next;
  logic                  o_free, a_adv;

  logic signed [C2_WIDTH:0] c2s;
  logic signed [PW-1:0]     prod, rnd_c, rnd;
  logic signed [TW-1:0]     term;
  logic [SW-1:0]            total;
  logic [5:0]               top_bits;
  logic signed [W-1:0]      sat_val;
  status_t                  sat_st;

  assign o_free    = !results.valid || results.ready;
  assign a_adv     = a_valid && o_free;
  assign job_ready = !a_valid || o_free;

  assign lap_next  = {{2{job_right[W-1]}}, job_right} + {{2{job_left[W-1]}}, job_left}
                   - {job_mid[W-1], job_mid, 1'b0};
  assign base_next = {job_mid[W-1], job_mid, 1'b0} - {{2{job_old[W-1]}}, job_old};

  assign c2s   = {1'b0, c2};
  assign prod  = a_lap * c2s;
  assign rnd_c = PW'(1 << (FRAC_BITS - 1));
  assign rnd   = prod + rnd_c;
  assign term  = rnd[PW-1:FRAC_BITS];
  assign total = {{(SW-TW){term[TW-1]}}, term} + {{3{a_base[W+1]}}, a_base};
  assign top_bits = total[SW-1:W-1];

  always_comb begin
    sat_val = total[W-1:0];
    sat_st  = STATUS_OK;
    if (!((top_bits == '0) || (top_bits == '1))) begin
      sat_st  = STATUS_SAT;
      sat_val = total[SW-1] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid       <= 1'b0;
      results.valid <= 1'b0;
    end else begin
      if (job_ready) begin
        a_valid <= job_valid;
      end
      if (o_free) begin
        results.valid <= a_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_ready && job_valid) begin
      a_ctl  <= job_ctl;
      a_lap  <= lap_next;
      a_base <= base_next;
    end
    if (a_adv) begin
      results.point_index <= a_ctl.point_index;
      results.end_of_run  <= a_ctl.end_of_run;
      if (a_ctl.short_sweep) begin
        results.next_sample <= '0;
        results.status      <= STATUS_SHORT;
      end else begin
        results.next_sample <= sat_val;
        results.status      <= sat_st;
      end
    end
  end

endmodule

>>> rtl/wave_leapfrog_stencil_periodic.sv
// Top level of the 1-D leapfrog wave stencil on a periodic grid.
// Depends on wlsp_pkg, the three channel interfaces, wlsp_front, wlsp_stencil.
//
// Usage: grid points stream in on "points", one item per point, with
// last_point set on the final point of the sweep. Results leave on
// "results" in grid order, lagging the input by one point; the last point
// also yields the two wrap-around results (itself, then point zero, with
// end_of_run). A sweep of one or two points gives a single status-2 item.
// "cfg" writes courant_squared (unsigned Q1.16, values above 1.0 act as 1.0); it is
// always ready and should be written only while the block is idle.
// Throughput: one item per cycle while results are not stalled; the final
// point of a sweep holds the input while its three jobs drain through the
// one stencil unit. A result passes the Laplacian stage register and then
// the result register after the item that completes it is accepted.
// Reset clears the sweep state, window and head samples to zero and loads
// courant_squared with 0.25. When results are stalled the pipeline holds
// and points.ready drops once the job register is occupied.
module wave_leapfrog_stencil_periodic import wlsp_pkg::*; #(
  parameter int MAX_POINTS   = DEF_MAX_POINTS,
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  wlsp_cfg_if.sink      cfg,
  wlsp_point_if.sink    points,
  wlsp_result_if.source results
);

  logic [C2_WIDTH-1:0]           c2_reg, c2_eff;
  logic                          job_valid, job_ready;
  job_ctl_t                      job_ctl;
  logic signed [SAMPLE_WIDTH-1:0] job_left, job_mid, job_right, job_old;

  assign cfg.ready = 1'b1;
  assign c2_eff    = (c2_reg > C2_ONE) ? C2_ONE : c2_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      c2_reg <= C2_RESET;
    end else if (cfg.valid && cfg.ready) begin
      c2_reg <= cfg.courant_squared;
    end
  end

  wlsp_front #(
    .MAX_POINTS   (MAX_POINTS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .points    (points),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_ctl   (job_ctl),
    .job_left  (job_left),
    .job_mid   (job_mid),
    .job_right (job_right),
    .job_old   (job_old)
  );

  wlsp_stencil #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_stencil (
    .clk       (clk),
    .rst       (rst),
    .c2        (c2_eff),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job_ctl   (job_ctl),
    .job_left  (job_left),
    .job_mid   (job_mid),
    .job_right (job_right),
    .job_old   (job_old),
    .results   (results)
  );

endmodule
